[hdl/rmm_pkg.sv]
`timescale 1ns / 1ps

package rmm_pkg;

   // Width of the serial multiplier and divider datapaths.
   localparam int WIDE_W = 256;
   // Width of the signed accumulators that collect the parts of a moment sum.
   localparam int SACC_W = 258;
   // Width of the multiplier operand that is scanned one bit per cycle.
   localparam int MPL_W = 64;
   // Width of a pixel count.
   localparam int CNT_W = 25;
   localparam logic [CNT_W-1:0] CNT_MAX = 25'd16777216;

   // Constant factors of the pairwise update.
   localparam logic [MPL_W-1:0] MUL_THREE = 64'd3;
   localparam logic [MPL_W-1:0] MUL_FOUR = 64'd4;
   localparam logic [MPL_W-1:0] MUL_SIX = 64'd6;

   typedef struct packed {
      logic        ovf;
      logic [63:0] val;
   } sat_type;

   function automatic logic [SACC_W-1:0] sx64(input logic [63:0] v);
      return {{(SACC_W-64){v[63]}}, v};
   endfunction

   function automatic logic [SACC_W-1:0] neg_if(input logic [SACC_W-1:0] v, input logic neg);
      return neg ? (SACC_W'(0) - v) : v;
   endfunction

   function automatic logic [WIDE_W-1:0] mag(input logic [SACC_W-1:0] v);
      logic [SACC_W-1:0] t;
      t = v[SACC_W-1] ? (SACC_W'(0) - v) : v;
      return t[WIDE_W-1:0];
   endfunction

   // Saturate to [0, 2^63-1]; a negative value clamps to zero.
   function automatic sat_type sat_u63(input logic [SACC_W-1:0] v);
      sat_type r;
      if (v[SACC_W-1]) begin
         r.ovf = 1'b1;
         r.val = '0;
      end else if (|v[SACC_W-2:63]) begin
         r.ovf = 1'b1;
         r.val = {1'b0, {63{1'b1}}};
      end else begin
         r.ovf = 1'b0;
         r.val = {1'b0, v[62:0]};
      end
      return r;
   endfunction

   // Saturate to the signed 64-bit range.
   function automatic sat_type sat_s64(input logic [SACC_W-1:0] v);
      sat_type r;
      if ((&v[SACC_W-1:63]) || !(|v[SACC_W-1:63])) begin
         r.ovf = 1'b0;
         r.val = v[63:0];
      end else if (v[SACC_W-1]) begin
         r.ovf = 1'b1;
         r.val = {1'b1, 63'd0};
      end else begin
         r.ovf = 1'b1;
         r.val = {1'b0, {63{1'b1}}};
      end
      return r;
   endfunction

endpackage

[hdl/region_moment_merge.sv]
`timescale 1ns / 1ps

// Running statistics of one image region. Each request transaction carries
// the statistics of another region (count, mean, central moment sums M2..M4,
// intensity sum, minimum and maximum with pixel ids). With req_start_req set,
// or while the accumulator is empty, the transaction is loaded as it is;
// otherwise it is merged into the accumulator by the pairwise update.
// Every request produces exactly one response transaction holding the new
// accumulator contents and an overflow flag for any saturated value.
// A load skips the sequencer and goes straight to the commit state. A merge
// runs a sequencer over one shift-add multiplier (one multiplier bit per
// cycle) and one restoring divider; a merge has 7 divisions and 28 products.
// One request is processed at a time; req_ready is high only while the block
// is idle. The result sits in an output register, so a new request is taken
// while the previous response still waits for rsp_ready; when the receiver
// stalls longer, the finished result waits in the sequencer until the output
// register frees up. Synchronous reset clears the accumulator to zero and
// drops any transaction in flight.
module region_moment_merge import rmm_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_start_req,
   input  logic [24:0]        req_count,
   input  logic signed [31:0] req_mean,
   input  logic [62:0]        req_m2,
   input  logic signed [63:0] req_m3,
   input  logic [62:0]        req_m4,
   input  logic signed [31:0] req_min_value,
   input  logic [23:0]        req_min_pixel,
   input  logic signed [31:0] req_max_value,
   input  logic [23:0]        req_max_pixel,
   input  logic signed [63:0] req_intensity_sum,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [24:0]        rsp_total_count,
   output logic signed [31:0] rsp_merged_mean,
   output logic [62:0]        rsp_merged_m2,
   output logic signed [63:0] rsp_merged_m3,
   output logic [62:0]        rsp_merged_m4,
   output logic signed [31:0] rsp_merged_min,
   output logic [23:0]        rsp_merged_min_pixel,
   output logic signed [31:0] rsp_merged_max,
   output logic [23:0]        rsp_merged_max_pixel,
   output logic signed [63:0] rsp_merged_sum,
   output logic               rsp_overflow
);

   typedef enum logic [1:0] {ST_IDLE, ST_GO, ST_WAIT, ST_DONE} state_type;

   // One entry per multiply or divide of the merge, in execution order.
   typedef enum logic [5:0] {
      SP_D2, SP_D3, SP_D4, SP_NAB, SP_NN, SP_N3, SP_NA2, SP_NB2,
      SP_MEAN_A, SP_MEAN_B, SP_MEAN_DIV,
      SP_M2_MUL, SP_M2_DIV,
      SP_M3_A1, SP_M3_A2, SP_M3_A3,
      SP_M3_B1, SP_M3_B2, SP_M3_B3, SP_M3_B4, SP_M3_B5,
      SP_M4_A1, SP_M4_A2, SP_M4_A3,
      SP_M4_B1, SP_M4_B2, SP_M4_B3, SP_M4_B4, SP_M4_B5, SP_M4_B6,
      SP_M4_C1, SP_M4_C2, SP_M4_C3, SP_M4_C4, SP_M4_C5
   } step_type;

   state_type state_ff;
   step_type  step_ff;
   logic      rsp_valid_ff;

   // Accumulator.
   logic [24:0] acc_count_ff;
   logic [31:0] acc_mean_ff;
   logic [62:0] acc_m2_ff;
   logic [63:0] acc_m3_ff;
   logic [62:0] acc_m4_ff;
   logic [31:0] acc_min_ff;
   logic [23:0] acc_min_pixel_ff;
   logic [31:0] acc_max_ff;
   logic [23:0] acc_max_pixel_ff;
   logic [63:0] acc_sum_ff;

   // Captured request.
   logic        load_ff;
   logic [31:0] in_mean_ff;
   logic [62:0] in_m2_ff;
   logic [63:0] in_m3_ff;
   logic [62:0] in_m4_ff;
   logic [31:0] in_min_ff;
   logic [23:0] in_min_pixel_ff;
   logic [31:0] in_max_ff;
   logic [23:0] in_max_pixel_ff;
   logic [63:0] in_sum_ff;

   // Merge working registers.
   logic [24:0]       na_ff;
   logic [24:0]       nb_ff;
   logic [25:0]       n_ff;
   logic [31:0]       dmag_ff;
   logic              dneg_ff;
   logic [31:0]       samag_ff;
   logic              saneg_ff;
   logic [31:0]       sbmag_ff;
   logic              sbneg_ff;
   logic [63:0]       d2_ff;
   logic [95:0]       d3_ff;
   logic [127:0]      d4_ff;
   logic [48:0]       nab_ff;
   logic [50:0]       nn_ff;
   logic [75:0]       n3_ff;
   logic [48:0]       na2_ff;
   logic [48:0]       nb2_ff;
   logic [SACC_W-1:0] sacc_ff;
   logic [SACC_W-1:0] tacc_ff;
   logic [31:0]       mean_new_ff;
   logic [62:0]       m2_new_ff;
   logic [63:0]       m3_new_ff;
   logic [62:0]       m4_new_ff;
   logic              ovf_ff;

   // Output register.
   logic [24:0] rsp_count_ff;
   logic [31:0] rsp_mean_ff;
   logic [62:0] rsp_m2_ff;
   logic [63:0] rsp_m3_ff;
   logic [62:0] rsp_m4_ff;
   logic [31:0] rsp_min_ff;
   logic [23:0] rsp_min_pixel_ff;
   logic [31:0] rsp_max_ff;
   logic [23:0] rsp_max_pixel_ff;
   logic [63:0] rsp_sum_ff;
   logic        rsp_ovf_ff;

   // Request-side decode.
   logic        cnt_clamp;
   logic [24:0] cnt_in;
   logic [32:0] d_full;
   logic [32:0] d_negv;
   logic [31:0] req_mean_u;
   logic [31:0] acc_mean_neg;
   logic [31:0] req_mean_neg;
   logic        do_load;

   // Serial unit connections.
   logic              mul_start;
   logic              mul_done;
   logic [WIDE_W-1:0] mul_a;
   logic [MPL_W-1:0]  mul_b;
   logic [WIDE_W-1:0] mul_prod;
   logic              div_start;
   logic              div_done;
   logic [WIDE_W-1:0] div_num;
   logic [WIDE_W-1:0] div_den;
   logic [WIDE_W-1:0] div_quo;
   logic              is_div;
   logic              unit_done;

   logic [WIDE_W-1:0] den1;
   logic [WIDE_W-1:0] den2;
   logic [WIDE_W-1:0] den3;
   logic [24:0]       ndiff;
   logic              na_lt_nb;
   logic [50:0]       quad;
   logic [SACC_W-1:0] prod_x;
   logic [SACC_W-1:0] quo_x;
   logic [63:0]       in_m3_mag;
   logic [63:0]       acc_m3_mag;

   // Commit values.
   logic [24:0] new_count;
   logic [31:0] new_mean;
   logic [62:0] new_m2;
   logic [63:0] new_m3;
   logic [62:0] new_m4;
   logic [31:0] new_min;
   logic [23:0] new_min_pixel;
   logic [31:0] new_max;
   logic [23:0] new_max_pixel;
   logic [63:0] new_sum;
   logic        new_ovf;
   sat_type     sum_sat;
   sat_type     fin_sat;

   always_comb begin
      cnt_clamp = req_count > CNT_MAX;
      cnt_in = cnt_clamp ? CNT_MAX : req_count;
      req_mean_u = req_mean;
      d_full = {req_mean_u[31], req_mean_u} - {acc_mean_ff[31], acc_mean_ff};
      d_negv = 33'd0 - d_full;
      acc_mean_neg = 32'd0 - acc_mean_ff;
      req_mean_neg = 32'd0 - req_mean_u;
      do_load = req_start_req || (acc_count_ff == '0);
   end

   always_comb begin
      den1 = WIDE_W'(n_ff) << FRAC_BITS;
      den2 = WIDE_W'(nn_ff) << (2 * FRAC_BITS);
      den3 = WIDE_W'(n3_ff) << (3 * FRAC_BITS);
      na_lt_nb = na_ff < nb_ff;
      ndiff = na_lt_nb ? (nb_ff - na_ff) : (na_ff - nb_ff);
      quad = nn_ff - ({nab_ff, 1'b0} + 51'(nab_ff));
      prod_x = SACC_W'(mul_prod);
      quo_x = SACC_W'(div_quo);
      in_m3_mag = in_m3_ff[63] ? (64'd0 - in_m3_ff) : in_m3_ff;
      acc_m3_mag = acc_m3_ff[63] ? (64'd0 - acc_m3_ff) : acc_m3_ff;
   end

   // Operand selection for the current step.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      div_num = mul_prod;
      div_den = den1;
      is_div = 1'b0;
      case (step_ff)
         SP_D2: begin
            mul_a = WIDE_W'(dmag_ff);
            mul_b = MPL_W'(dmag_ff);
         end
         SP_D3: begin
            mul_a = WIDE_W'(d2_ff);
            mul_b = MPL_W'(dmag_ff);
         end
         SP_D4: begin
            mul_a = WIDE_W'(d3_ff);
            mul_b = MPL_W'(dmag_ff);
         end
         SP_NAB: begin
            mul_a = WIDE_W'(na_ff);
            mul_b = MPL_W'(nb_ff);
         end
         SP_NN: begin
            mul_a = WIDE_W'(n_ff);
            mul_b = MPL_W'(n_ff);
         end
         SP_N3: begin
            mul_a = WIDE_W'(nn_ff);
            mul_b = MPL_W'(n_ff);
         end
         SP_NA2: begin
            mul_a = WIDE_W'(na_ff);
            mul_b = MPL_W'(na_ff);
         end
         SP_NB2: begin
            mul_a = WIDE_W'(nb_ff);
            mul_b = MPL_W'(nb_ff);
         end
         SP_MEAN_A: begin
            mul_a = WIDE_W'(samag_ff);
            mul_b = MPL_W'(na_ff);
         end
         SP_MEAN_B: begin
            mul_a = WIDE_W'(sbmag_ff);
            mul_b = MPL_W'(nb_ff);
         end
         SP_MEAN_DIV: begin
            is_div = 1'b1;
            div_num = mag(sacc_ff);
            div_den = WIDE_W'(n_ff);
         end
         SP_M2_MUL: begin
            mul_a = WIDE_W'(d2_ff);
            mul_b = MPL_W'(nab_ff);
         end
         SP_M2_DIV: is_div = 1'b1;
         SP_M3_A1: begin
            mul_a = WIDE_W'(d3_ff);
            mul_b = MPL_W'(nab_ff);
         end
         SP_M3_A2: begin
            mul_a = mul_prod;
            mul_b = MPL_W'(ndiff);
         end
         SP_M3_A3: begin
            is_div = 1'b1;
            div_den = den2;
         end
         SP_M3_B1: begin
            mul_a = WIDE_W'(in_m2_ff);
            mul_b = MPL_W'(na_ff);
         end
         SP_M3_B2: begin
            mul_a = WIDE_W'(acc_m2_ff);
            mul_b = MPL_W'(nb_ff);
         end
         SP_M3_B3: begin
            mul_a = mag(tacc_ff);
            mul_b = MUL_THREE;
         end
         SP_M3_B4: begin
            mul_a = mul_prod;
            mul_b = MPL_W'(dmag_ff);
         end
         SP_M3_B5: is_div = 1'b1;
         SP_M4_A1: begin
            mul_a = WIDE_W'(d4_ff);
            mul_b = MPL_W'(nab_ff);
         end
         SP_M4_A2: begin
            mul_a = mul_prod;
            mul_b = MPL_W'(quad);
         end
         SP_M4_A3: begin
            is_div = 1'b1;
            div_den = den3;
         end
         SP_M4_B1: begin
            mul_a = WIDE_W'(in_m2_ff);
            mul_b = MPL_W'(na2_ff);
         end
         SP_M4_B2: begin
            mul_a = WIDE_W'(acc_m2_ff);
            mul_b = MPL_W'(nb2_ff);
         end
         SP_M4_B3: begin
            mul_a = mag(tacc_ff);
            mul_b = MUL_SIX;
         end
         SP_M4_B4, SP_M4_B5, SP_M4_C4: begin
            mul_a = mul_prod;
            mul_b = MPL_W'(dmag_ff);
         end
         SP_M4_B6: begin
            is_div = 1'b1;
            div_den = den2;
         end
         SP_M4_C1: begin
            mul_a = WIDE_W'(in_m3_mag);
            mul_b = MPL_W'(na_ff);
         end
         SP_M4_C2: begin
            mul_a = WIDE_W'(acc_m3_mag);
            mul_b = MPL_W'(nb_ff);
         end
         SP_M4_C3: begin
            mul_a = mag(tacc_ff);
            mul_b = MUL_FOUR;
         end
         SP_M4_C5: is_div = 1'b1;
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_start = (state_ff == ST_GO) && !is_div;
   assign div_start = (state_ff == ST_GO) && is_div;
   assign unit_done = is_div ? div_done : mul_done;

   rmm_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .mcand  (mul_a),
      .mplier (mul_b),
      .done   (mul_done),
      .prod   (mul_prod)
   );

   rmm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Values written back to the accumulator when the transaction finishes.
   always_comb begin
      sum_sat = sat_s64(sx64(acc_sum_ff) + sx64(in_sum_ff));
      if (load_ff) begin
         new_count = nb_ff;
         new_mean = in_mean_ff;
         new_m2 = in_m2_ff;
         new_m3 = in_m3_ff;
         new_m4 = in_m4_ff;
         new_min = in_min_ff;
         new_min_pixel = in_min_pixel_ff;
         new_max = in_max_ff;
         new_max_pixel = in_max_pixel_ff;
         new_sum = in_sum_ff;
         new_ovf = ovf_ff;
      end else begin
         new_count = (n_ff > 26'(CNT_MAX)) ? CNT_MAX : n_ff[24:0];
         new_mean = mean_new_ff;
         new_m2 = m2_new_ff;
         new_m3 = m3_new_ff;
         new_m4 = m4_new_ff;
         // The accumulator keeps its extreme only when strictly better.
         if ($signed(acc_min_ff) < $signed(in_min_ff)) begin
            new_min = acc_min_ff;
            new_min_pixel = acc_min_pixel_ff;
         end else begin
            new_min = in_min_ff;
            new_min_pixel = in_min_pixel_ff;
         end
         if ($signed(acc_max_ff) > $signed(in_max_ff)) begin
            new_max = acc_max_ff;
            new_max_pixel = acc_max_pixel_ff;
         end else begin
            new_max = in_max_ff;
            new_max_pixel = in_max_pixel_ff;
         end
         new_sum = sum_sat.val;
         new_ovf = ovf_ff || sum_sat.ovf || (n_ff > 26'(CNT_MAX));
      end
   end

   // Saturation at the end of each moment: the sum with the last term.
   always_comb begin
      case (step_ff)
         SP_M2_DIV: fin_sat = sat_u63(sacc_ff + quo_x);
         SP_M3_B5: fin_sat = sat_s64(sacc_ff + neg_if(quo_x, tacc_ff[SACC_W-1] != dneg_ff));
         SP_M4_C5: fin_sat = sat_u63(sacc_ff + neg_if(quo_x, tacc_ff[SACC_W-1] != dneg_ff));
         default: fin_sat = sat_u63(sacc_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= SP_D2;
         rsp_valid_ff <= 1'b0;
         acc_count_ff <= '0;
         acc_mean_ff <= '0;
         acc_m2_ff <= '0;
         acc_m3_ff <= '0;
         acc_m4_ff <= '0;
         acc_min_ff <= '0;
         acc_min_pixel_ff <= '0;
         acc_max_ff <= '0;
         acc_max_pixel_ff <= '0;
         acc_sum_ff <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  load_ff <= do_load;
                  ovf_ff <= cnt_clamp;
                  in_mean_ff <= req_mean_u;
                  in_m2_ff <= req_m2;
                  in_m3_ff <= req_m3;
                  in_m4_ff <= req_m4;
                  in_min_ff <= req_min_value;
                  in_min_pixel_ff <= req_min_pixel;
                  in_max_ff <= req_max_value;
                  in_max_pixel_ff <= req_max_pixel;
                  in_sum_ff <= req_intensity_sum;
                  na_ff <= acc_count_ff;
                  nb_ff <= cnt_in;
                  n_ff <= 26'(acc_count_ff) + 26'(cnt_in);
                  dneg_ff <= d_full[32];
                  dmag_ff <= d_full[32] ? d_negv[31:0] : d_full[31:0];
                  saneg_ff <= acc_mean_ff[31];
                  samag_ff <= acc_mean_ff[31] ? acc_mean_neg : acc_mean_ff;
                  sbneg_ff <= req_mean_u[31];
                  sbmag_ff <= req_mean_u[31] ? req_mean_neg : req_mean_u;
                  step_ff <= SP_D2;
                  state_ff <= do_load ? ST_DONE : ST_GO;
               end
            end
            ST_GO: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (unit_done) begin
                  state_ff <= ST_GO;
                  case (step_ff)
                     SP_D2: begin
                        d2_ff <= mul_prod[63:0];
                        step_ff <= SP_D3;
                     end
                     SP_D3: begin
                        d3_ff <= mul_prod[95:0];
                        step_ff <= SP_D4;
                     end
                     SP_D4: begin
                        d4_ff <= mul_prod[127:0];
                        step_ff <= SP_NAB;
                     end
                     SP_NAB: begin
                        nab_ff <= mul_prod[48:0];
                        step_ff <= SP_NN;
                     end
                     SP_NN: begin
                        nn_ff <= mul_prod[50:0];
                        step_ff <= SP_N3;
                     end
                     SP_N3: begin
                        n3_ff <= mul_prod[75:0];
                        step_ff <= SP_NA2;
                     end
                     SP_NA2: begin
                        na2_ff <= mul_prod[48:0];
                        step_ff <= SP_NB2;
                     end
                     SP_NB2: begin
                        nb2_ff <= mul_prod[48:0];
                        step_ff <= SP_MEAN_A;
                     end
                     SP_MEAN_A: begin
                        sacc_ff <= neg_if(prod_x, saneg_ff);
                        step_ff <= SP_MEAN_B;
                     end
                     SP_MEAN_B: begin
                        sacc_ff <= sacc_ff + neg_if(prod_x, sbneg_ff);
                        step_ff <= SP_MEAN_DIV;
                     end
                     SP_MEAN_DIV: begin
                        mean_new_ff <= sacc_ff[SACC_W-1] ? (32'd0 - div_quo[31:0])
                                                         : div_quo[31:0];
                        sacc_ff <= SACC_W'(acc_m2_ff) + SACC_W'(in_m2_ff);
                        step_ff <= SP_M2_MUL;
                     end
                     SP_M2_MUL: step_ff <= SP_M2_DIV;
                     SP_M2_DIV: begin
                        m2_new_ff <= fin_sat.val[62:0];
                        ovf_ff <= ovf_ff || fin_sat.ovf;
                        sacc_ff <= sx64(acc_m3_ff) + sx64(in_m3_ff);
                        step_ff <= SP_M3_A1;
                     end
                     SP_M3_A1: step_ff <= SP_M3_A2;
                     SP_M3_A2: step_ff <= SP_M3_A3;
                     SP_M3_A3: begin
                        sacc_ff <= sacc_ff + neg_if(quo_x, dneg_ff != na_lt_nb);
                        step_ff <= SP_M3_B1;
                     end
                     SP_M3_B1: begin
                        tacc_ff <= prod_x;
                        step_ff <= SP_M3_B2;
                     end
                     SP_M3_B2: begin
                        tacc_ff <= tacc_ff - prod_x;
                        step_ff <= SP_M3_B3;
                     end
                     SP_M3_B3: step_ff <= SP_M3_B4;
                     SP_M3_B4: step_ff <= SP_M3_B5;
                     SP_M3_B5: begin
                        m3_new_ff <= fin_sat.val;
                        ovf_ff <= ovf_ff || fin_sat.ovf;
                        sacc_ff <= SACC_W'(acc_m4_ff) + SACC_W'(in_m4_ff);
                        step_ff <= SP_M4_A1;
                     end
                     SP_M4_A1: step_ff <= SP_M4_A2;
                     SP_M4_A2: step_ff <= SP_M4_A3;
                     SP_M4_A3: begin
                        sacc_ff <= sacc_ff + quo_x;
                        step_ff <= SP_M4_B1;
                     end
                     SP_M4_B1: begin
                        tacc_ff <= prod_x;
                        step_ff <= SP_M4_B2;
                     end
                     SP_M4_B2: begin
                        tacc_ff <= tacc_ff + prod_x;
                        step_ff <= SP_M4_B3;
                     end
                     SP_M4_B3: step_ff <= SP_M4_B4;
                     SP_M4_B4: step_ff <= SP_M4_B5;
                     SP_M4_B5: step_ff <= SP_M4_B6;
                     SP_M4_B6: begin
                        sacc_ff <= sacc_ff + quo_x;
                        step_ff <= SP_M4_C1;
                     end
                     SP_M4_C1: begin
                        tacc_ff <= neg_if(prod_x, in_m3_ff[63]);
                        step_ff <= SP_M4_C2;
                     end
                     SP_M4_C2: begin
                        tacc_ff <= tacc_ff - neg_if(prod_x, acc_m3_ff[63]);
                        step_ff <= SP_M4_C3;
                     end
                     SP_M4_C3: step_ff <= SP_M4_C4;
                     SP_M4_C4: step_ff <= SP_M4_C5;
                     SP_M4_C5: begin
                        m4_new_ff <= fin_sat.val[62:0];
                        ovf_ff <= ovf_ff || fin_sat.ovf;
                        state_ff <= ST_DONE;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  acc_count_ff <= new_count;
                  acc_mean_ff <= new_mean;
                  acc_m2_ff <= new_m2;
                  acc_m3_ff <= new_m3;
                  acc_m4_ff <= new_m4;
                  acc_min_ff <= new_min;
                  acc_min_pixel_ff <= new_min_pixel;
                  acc_max_ff <= new_max;
                  acc_max_pixel_ff <= new_max_pixel;
                  acc_sum_ff <= new_sum;
                  rsp_count_ff <= new_count;
                  rsp_mean_ff <= new_mean;
                  rsp_m2_ff <= new_m2;
                  rsp_m3_ff <= new_m3;
                  rsp_m4_ff <= new_m4;
                  rsp_min_ff <= new_min;
                  rsp_min_pixel_ff <= new_min_pixel;
                  rsp_max_ff <= new_max;
                  rsp_max_pixel_ff <= new_max_pixel;
                  rsp_sum_ff <= new_sum;
                  rsp_ovf_ff <= new_ovf;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_total_count = rsp_count_ff;
   assign rsp_merged_mean = rsp_mean_ff;
   assign rsp_merged_m2 = rsp_m2_ff;
   assign rsp_merged_m3 = rsp_m3_ff;
   assign rsp_merged_m4 = rsp_m4_ff;
   assign rsp_merged_min = rsp_min_ff;
   assign rsp_merged_min_pixel = rsp_min_pixel_ff;
   assign rsp_merged_max = rsp_max_ff;
   assign rsp_merged_max_pixel = rsp_max_pixel_ff;
   assign rsp_merged_sum = rsp_sum_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

[hdl/rmm_mul.sv]
`timescale 1ns / 1ps

// Shift-add multiplier: one multiplier bit per cycle, stops when the
// remaining multiplier bits are all zero.
module rmm_mul import rmm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] mcand,
   input  logic [MPL_W-1:0]  mplier,
   output logic              done,
   output logic [WIDE_W-1:0] prod
);

   logic              run_ff;
   logic              done_ff;
   logic [WIDE_W-1:0] mcand_ff;
   logic [MPL_W-1:0]  mplier_ff;
   logic [WIDE_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            mcand_ff <= mcand;
            mplier_ff <= mplier;
            prod_ff <= '0;
         end else if (run_ff) begin
            if (mplier_ff == '0) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               if (mplier_ff[0]) begin
                  prod_ff <= prod_ff + mcand_ff;
               end
               mcand_ff <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

[hdl/rmm_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, followed by a rounding
// step (nearest, ties away from zero). The divisor is never zero here.
module rmm_div import rmm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WIDE_W-1:0] num,
   input  logic [WIDE_W-1:0] den,
   output logic              done,
   output logic [WIDE_W-1:0] quo
);

   localparam int IDX_W = $clog2(WIDE_W);

   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_ROUND} dv_state_type;

   dv_state_type      state_ff;
   logic              done_ff;
   logic [IDX_W-1:0]  cnt_ff;
   logic [WIDE_W-1:0] quo_ff;
   logic [WIDE_W-1:0] rem_ff;
   logic [WIDE_W-1:0] den_ff;

   logic [WIDE_W:0]   rem_sh;
   logic [WIDE_W:0]   rem_diff;
   logic              rem_ge;
   logic              round_up;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[WIDE_W-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      rem_ge = rem_sh >= {1'b0, den_ff};
      round_up = {rem_ff, 1'b0} >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  quo_ff <= num;
                  den_ff <= den;
                  rem_ff <= '0;
                  cnt_ff <= IDX_W'(WIDE_W - 1);
                  state_ff <= DV_RUN;
               end
            end
            DV_RUN: begin
               rem_ff <= rem_ge ? rem_diff[WIDE_W-1:0] : rem_sh[WIDE_W-1:0];
               quo_ff <= {quo_ff[WIDE_W-2:0], rem_ge};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= DV_ROUND;
               end
            end
            DV_ROUND: begin
               if (round_up) begin
                  quo_ff <= quo_ff + 1'b1;
               end
               done_ff <= 1'b1;
               state_ff <= DV_IDLE;
            end
            default: state_ff <= DV_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;

endmodule
